// ----- hw/rtl/ssbi_pkg.sv -----
package ssbi_pkg;

	localparam int unsigned RowCount = 32;
	localparam int unsigned SboxSize = 256;

	typedef enum logic [1:0] {
		MODE_LOAD_ROW  = 2'd0,
		MODE_LOAD_SBOX = 2'd1,
		MODE_TRANSFORM = 2'd2,
		MODE_UNUSED    = 2'd3
	} mode_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = xtime(x);
		end
		gf_mul = acc;
	endfunction

	// aes inverse s-box as a constant table
	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

endpackage

// ----- hw/rtl/ssbi_lane.sv -----
// one byte lane: inverse s-box and round mask
module ssbi_lane (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] mask,
	input  logic [7:0] lin_byte,
	output logic [7:0] s_s3
);
	import ssbi_pkg::*;

	always_ff @(posedge clk) begin
		if (en) s_s3 <= INV_SBOX[lin_byte] ^ mask;
	end
endmodule

// ----- hw/rtl/ssbi_mix.sv -----
// invmixcolumns across the four lanes
module ssbi_mix (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] s_word,
	output logic [31:0] t_s4
);
	import ssbi_pkg::*;

	logic [7:0] s [4];
	logic [7:0] sum;
	logic [31:0] t;

	always_comb begin
		for (int i = 0; i < 4; i++) s[i] = s_word[8*i +: 8];
		sum = gf_mul(8'h09, s[0] ^ s[1] ^ s[2] ^ s[3]);
		for (int i = 0; i < 4; i++) begin
			t[8*i +: 8] = s[i] ^ sum ^ gf_mul(8'h04, s[i] ^ s[(i+2)%4])
				^ gf_mul(8'h02, s[i] ^ s[(i+1)%4]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) t_s4 <= t;
	end
endmodule

// ----- hw/rtl/super_sbox_inverse_datapath_unit.sv -----
// inverse super s-box with a loaded 32x32 gf(2) linear layer
// one input channel (valid/stall) carries mode, index and data_word:
//   mode 0 loads matrix row index (indexes 32 and up ignored), mode 1 loads
//   secret inverse s-box entry index from data_word[7:0], mode 2 transforms
//   data_word; mode 3 is ignored. loads give no result item.
// results leave on the output channel (valid/stall) as result_word.
// all rows and all s-box entries must be loaded before the first transform.
// pipeline: s1 matrix product of the incoming word, s2 product register,
//   s3 inverse s-box lanes, s4 invmixcolumns, s5 aes inverse s-box,
//   s6 secret s-box read, one memory copy per byte lane.
// secret s-box loads travel five stages before landing, so they stay in order
//   with the transforms around them.
// result valid once the item has passed stages s1 to s6; one item per cycle while the receiver does not stall.
// a receiver stall freezes the whole pipeline; in_stall follows it, so the
// last stage acts as the output register.
// reset clears the stage valid bits; the stores stay undefined until loaded.
module super_sbox_inverse_datapath_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  index,
	input  logic [31:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_word
);
	import ssbi_pkg::*;

	logic [31:0] rows_q [RowCount];
	logic [5:0]  vld_q;
	logic [4:0]  sbox_we_q;
	logic [7:0]  sbox_addr_q [5];
	logic [7:0]  sbox_data_q [5];
	logic        en;
	logic        take;
	logic [31:0] lin;
	logic [31:0] lin_s1;
	logic [31:0] lin_s2;
	logic [31:0] s_s3;
	logic [31:0] t_s4;
	logic [31:0] u_s5;
	logic [31:0] r_s6;
	localparam logic [31:0] MASK = 32'h63636362;

	assign en = !out_stall;
	assign in_stall = out_stall;
	assign take = in_valid && !out_stall;
	assign out_valid = vld_q[5];
	assign result_word = r_s6;

	always_ff @(posedge clk) begin
		if (take && mode == MODE_LOAD_ROW && index < 8'(RowCount))
			rows_q[index[4:0]] <= data_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			sbox_we_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid && mode == MODE_TRANSFORM};
			sbox_we_q <= {sbox_we_q[3:0], in_valid && mode == MODE_LOAD_SBOX};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sbox_addr_q[0] <= index;
			sbox_data_q[0] <= data_word[7:0];
			for (int i = 1; i < 5; i++) begin
				sbox_addr_q[i] <= sbox_addr_q[i-1];
				sbox_data_q[i] <= sbox_data_q[i-1];
			end
		end
	end

	// independent parity per row
	always_comb begin
		for (int r = 0; r < 32; r++) lin[r] = ^(rows_q[r] & data_word);
	end

	always_ff @(posedge clk) begin
		if (take) lin_s1 <= lin;
	end

	always_ff @(posedge clk) begin
		if (en) lin_s2 <= lin_s1;
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		ssbi_lane u_lane (
			.clk      (clk),
			.en       (en),
			.mask     (MASK[8*g +: 8]),
			.lin_byte (lin_s2[8*g +: 8]),
			.s_s3     (s_s3[8*g +: 8])
		);
	end

	ssbi_mix u_mix (
		.clk    (clk),
		.en     (en),
		.s_word (s_s3),
		.t_s4   (t_s4)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) u_s5[8*i +: 8] <= INV_SBOX[t_s4[8*i +: 8]];
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_secret
		logic [7:0] sbox_mem [SboxSize];
		logic [7:0] rd_s6;

		always_ff @(posedge clk) begin
			if (en && sbox_we_q[4]) sbox_mem[sbox_addr_q[4]] <= sbox_data_q[4];
			if (en) rd_s6 <= sbox_mem[u_s5[8*g +: 8]];
		end

		assign r_s6[8*g +: 8] = rd_s6;
	end
endmodule

// ----- verif/ssbi_checker.sv -----
`timescale 1ns / 100ps

module ssbi_checker (
	input  logic        clk,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  index,
	input  logic [31:0] data_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_word,
	output int          fail_count,
	output int          words_pending
);
	import ssbi_pkg::*;

	logic [31:0] row_model [RowCount];
	logic [7:0]  secret_model [SboxSize];
	logic [31:0] expected_words [$];

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	// x^254, zero stays zero
	function automatic logic [7:0] gf_recip(input logic [7:0] x);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 0; i < 254; i++) r = gf_times(r, x);
		return r;
	endfunction

	function automatic logic [7:0] unsub_byte(input logic [7:0] x);
		logic [7:0] y;
		y = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
		return gf_recip(y);
	endfunction

	function automatic logic [31:0] unmix_word(input logic [31:0] w);
		logic [31:0] lin, res;
		logic [7:0] s [4];
		logic [7:0] t, msum;
		logic [7:0] mask [4];
		mask = '{8'h62, 8'h63, 8'h63, 8'h63};
		for (int r = 0; r < 32; r++) lin[r] = ^(row_model[r] & w);
		for (int i = 0; i < 4; i++) s[i] = unsub_byte(lin[8*i +: 8]) ^ mask[i];
		msum = gf_times(8'h09, s[0] ^ s[1] ^ s[2] ^ s[3]);
		for (int i = 0; i < 4; i++) begin
			t = s[i] ^ msum ^ gf_times(8'h04, s[i] ^ s[(i+2)%4])
				^ gf_times(8'h02, s[i] ^ s[(i+1)%4]);
			res[8*i +: 8] = secret_model[unsub_byte(t)];
		end
		return res;
	endfunction

	initial begin
		fail_count = 0;
		words_pending = 0;
		for (int i = 0; i < RowCount; i++) row_model[i] = '0;
		for (int i = 0; i < SboxSize; i++) secret_model[i] = '0;
	end

	always @(posedge clk) begin
		logic [31:0] exp_w;
		if (in_valid && !in_stall) begin
			case (mode_t'(mode))
				MODE_LOAD_ROW: begin
					if (index < RowCount) row_model[index[4:0]] = data_word;
				end
				MODE_LOAD_SBOX: begin
					secret_model[index] = data_word[7:0];
				end
				MODE_TRANSFORM: begin
					expected_words = {expected_words, unmix_word(data_word)};
				end
				default: ;
			endcase
		end
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, result_word);
				fail_count++;
			end else begin
				exp_w = expected_words.pop_front();
				if (exp_w !== result_word) begin
					$display("%0t: result_word expected %h actual %h", $time, exp_w,
						result_word);
					fail_count++;
				end
			end
		end
		words_pending = expected_words.size();
	end

endmodule

// ----- verif/tb_super_sbox_inverse_datapath_unit.sv -----
`timescale 1ns / 100ps

module tb_super_sbox_inverse_datapath_unit;
	import ssbi_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_UNUSED;
	logic [7:0]  index = '0;
	logic [31:0] data_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_word;
	int          fail_count;
	int          words_pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	always #2 clk = ~clk;

	super_sbox_inverse_datapath_unit dut (.*);

	ssbi_checker chk (
		.clk, .in_valid, .in_stall, .mode, .index, .data_word,
		.out_valid, .out_stall, .result_word, .fail_count, .words_pending
	);

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	initial begin
		#4ms;
		$display("super_sbox_inverse_datapath_unit test failed");
		$finish;
	end

	task automatic send_item(input mode_t m, input logic [7:0] idx, input logic [31:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		index <= idx;
		data_word <= d;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_items(input int count);
		int pick;
		logic [31:0] w;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			w = $urandom();
			if (pick < 6) w = (pick < 3) ? 32'h0 : 32'hffff_ffff;
			if (pick < 78) send_item(MODE_TRANSFORM, 8'($urandom_range(255)), w);
			else if (pick < 86) send_item(MODE_LOAD_ROW, 8'($urandom_range(255)), w);
			else if (pick < 96) send_item(MODE_LOAD_SBOX, 8'($urandom_range(255)), w);
			else send_item(MODE_UNUSED, 8'($urandom_range(255)), w);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every row and sbox entry written before any transform
		for (int r = 0; r < RowCount; r++) send_item(MODE_LOAD_ROW, 8'(r), $urandom());
		for (int a = 0; a < SboxSize; a++) send_item(MODE_LOAD_SBOX, 8'(a), $urandom());

		send_item(MODE_TRANSFORM, 8'h00, 32'h0000_0000);
		send_item(MODE_TRANSFORM, 8'hff, 32'hffff_ffff);
		send_item(MODE_TRANSFORM, 8'h00, 32'h0000_0001);
		send_item(MODE_TRANSFORM, 8'h00, 32'h8000_0000);
		// row 0 set to all ones and row 31 to zero, then a transform
		send_item(MODE_LOAD_ROW, 8'd0, 32'hffff_ffff);
		send_item(MODE_LOAD_ROW, 8'd31, 32'h0000_0000);
		send_item(MODE_TRANSFORM, 8'h00, 32'h1234_5678);
		// out of range rows are ignored
		send_item(MODE_LOAD_ROW, 8'd32, 32'hdead_beef);
		send_item(MODE_LOAD_ROW, 8'd255, 32'h0000_0000);
		send_item(MODE_TRANSFORM, 8'h00, 32'hffff_ffff);
		// only the low byte of sbox data is kept
		send_item(MODE_LOAD_SBOX, 8'h00, 32'hffff_ff00);
		send_item(MODE_LOAD_SBOX, 8'hff, 32'h0000_00ff);
		send_item(MODE_TRANSFORM, 8'h00, 32'h0000_0000);
		send_item(MODE_UNUSED, 8'hff, 32'hffff_ffff);
		send_item(MODE_TRANSFORM, 8'h00, 32'ha5a5_5a5a);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 53 : (ph == 3) ? 13 : 0;
			stall_pct = (ph == 2) ? 53 : (ph == 3) ? 13 : 0;
			random_items(387);
			drain();
		end
		stall_pct = 0;

		if (fail_count == 0) begin
			$display("super_sbox_inverse_datapath_unit test passed");
		end else begin
			$display("super_sbox_inverse_datapath_unit test failed");
		end
		$finish;
	end

endmodule
